@@ sv/sink_attach_frame_filter_macros.svh @@
// Assertion macros used by the frame filter checker.
`ifndef SINK_ATTACH_FRAME_FILTER_MACROS_SVH
`define SINK_ATTACH_FRAME_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/saff_pkg.sv @@
// Shared types and constants of the sink frame filter.
`default_nettype none

package saff_pkg;

  // Default sizing
  localparam int MAX_NODES_DEF   = 10;
  localparam int MAX_PAYLOAD_DEF = 60;
  localparam int QUEUE_DEPTH     = 2;

  // Frame header codes
  localparam logic [7:0] BCAST_ADDR        = 8'hFF;
  localparam logic [7:0] TYPE_ATTACH_REQ   = 8'h01;
  localparam logic [7:0] TYPE_DATA         = 8'h03;
  localparam logic [1:0] TYPE_ATTACH_REPLY = 2'd2;
  localparam logic [1:0] REPLY_LEN         = 2'd3;
  localparam logic [7:0] HDR_LEN           = 8'd3;

  typedef enum logic [2:0] {
    ACT_BAD_CRC       = 3'd0,
    ACT_BAD_LENGTH    = 3'd1,
    ACT_NOT_ADDRESSED = 3'd2,
    ACT_BAD_TYPE      = 3'd3,
    ACT_TABLE_FULL    = 3'd4,
    ACT_REPLY         = 3'd5,
    ACT_DELIVER       = 3'd6
  } action_e;

  // Classified request, front to back
  typedef struct packed {
    logic       attach;  // well-formed attach request, needs table lookup
    action_e    action;  // final action when not an attach
    logic [7:0] src;
    logic [7:0] dlen;
  } req_t;

  // Result item
  typedef struct packed {
    action_e    action;
    logic [7:0] reply_dest;
    logic [7:0] reply_source;
    logic [1:0] reply_type;
    logic [1:0] reply_length;
    logic       new_node;
    logic [7:0] deliver_source;
    logic [7:0] deliver_length;
    logic [3:0] attached_count;
  } res_t;

endpackage

`default_nettype wire

@@ sv/saff_fifo.sv @@
// Small synchronous queue used between front and back and at the output.
`default_nettype none

module saff_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update, wrapping at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/saff_front.sv @@
// Front end: accepts frame headers and classifies them by the header checks.
`default_nettype none

module saff_front #(
  parameter int MAX_PAYLOAD = saff_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic       push_i,
  input  wire logic       q_full_i,
  input  wire logic       crc_good_i,
  input  wire logic [7:0] frame_length_i,
  input  wire logic [7:0] source_address_i,
  input  wire logic [7:0] dest_address_i,
  input  wire logic [7:0] frame_type_i,
  input  wire logic [7:0] coord_address_i,
  output logic            q_push_o,
  output saff_pkg::req_t  req_o
);

  import saff_pkg::*;

  localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD + 3);

  assign q_push_o = push_i && !q_full_i;

  // Checks in priority order: CRC, length, address, type
  always_comb begin
    req_o        = '0;
    req_o.src    = source_address_i;
    req_o.action = ACT_BAD_TYPE;
    if (!crc_good_i) begin
      req_o.action = ACT_BAD_CRC;
    end else if ({1'b0, frame_length_i} > LEN_LIMIT) begin
      req_o.action = ACT_BAD_LENGTH;
    end else if ((dest_address_i != coord_address_i) && (dest_address_i != BCAST_ADDR)) begin
      req_o.action = ACT_NOT_ADDRESSED;
    end else if (frame_type_i == TYPE_ATTACH_REQ) begin
      // only a header-only attach request goes to the table
      req_o.attach = (frame_length_i == HDR_LEN);
    end else if (frame_type_i == TYPE_DATA) begin
      if (frame_length_i >= HDR_LEN) begin
        req_o.action = ACT_DELIVER;
        req_o.dlen   = frame_length_i - HDR_LEN;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/saff_back.sv @@
// Back end: node table search and update, builds one result per request.
`default_nettype none

module saff_back #(
  parameter int MAX_NODES = saff_pkg::MAX_NODES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] coord_address_i,
  input  wire logic       q_empty_i,
  input  wire saff_pkg::req_t q_req_i,
  output logic            q_pop_o,
  input  wire logic       out_full_i,
  output logic            out_push_o,
  output saff_pkg::res_t  out_res_o
);

  import saff_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  res_t             res_q, res_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             found_q, found_d;
  logic             rd_vld_q;
  logic [7:0]       rd_data_q;
  logic             issue, hit, tbl_we;

  // Attached node table, one write port and one registered read port
  logic [7:0] tbl_mem [MAX_NODES];

  assign issue     = (state_q == ST_SEARCH) && (idx_q < total_q);
  assign hit       = rd_vld_q && (rd_data_q == req_q.src);
  assign out_res_o = res_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    idx_d      = idx_q;
    total_d    = total_q;
    found_d    = found_q;
    q_pop_o    = 1'b0;
    out_push_o = 1'b0;
    tbl_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          req_d   = q_req_i;
          if (q_req_i.attach) begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = (total_q == '0) ? ST_DECIDE : ST_SEARCH;
          end else begin
            res_d                = '0;
            res_d.action         = q_req_i.action;
            res_d.attached_count = 4'(total_q);
            if (q_req_i.action == ACT_DELIVER) begin
              res_d.deliver_source = q_req_i.src;
              res_d.deliver_length = q_req_i.dlen;
            end
            state_d = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        // one table read per cycle, compared in the following cycle
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else if (!issue && rd_vld_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d = '0;
        if (!found_q && (total_q >= CNT_W'(MAX_NODES))) begin
          res_d.action         = ACT_TABLE_FULL;
          res_d.attached_count = 4'(total_q);
        end else begin
          res_d.action       = ACT_REPLY;
          res_d.reply_dest   = req_q.src;
          res_d.reply_source = coord_address_i;
          res_d.reply_type   = TYPE_ATTACH_REPLY;
          res_d.reply_length = REPLY_LEN;
          if (found_q) begin
            res_d.attached_count = 4'(total_q);
          end else begin
            tbl_we               = 1'b1;
            total_d              = total_q + 1'b1;
            res_d.new_node       = 1'b1;
            res_d.attached_count = 4'(total_d);
          end
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      total_q  <= '0;
      found_q  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      found_q  <= found_d;
      rd_vld_q <= issue;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[total_q[IDX_W-1:0]] <= req_q.src;
    end
    rd_data_q <= tbl_mem[idx_q[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

@@ sv/sink_attach_frame_filter.sv @@
// Top level of the sink frame filter: config register, front, queues, back.
`default_nettype none

// Received frame headers are pushed into a two-entry queue after the header
// checks (CRC, length, address, type); the back end pops them and writes one
// result per header into a two-entry output queue, so a waiting result stalls
// intake only once both queues have filled. A header that needs no table
// lookup goes from idle straight to emit; an attach request goes through
// search, decide and emit, the search skipped on an empty table and stopped
// early when the node is found. The search reads the node table (one write,
// one read port) one entry per cycle; the back end takes no new header
// before its last result is pushed. The node table needs no clearing after
// reset; coord_address resets to 0; the user must write it through cfg_we_i
// / cfg_data_i only while the block is idle, which the block does not enforce.

module sink_attach_frame_filter #(
  parameter int MAX_NODES   = saff_pkg::MAX_NODES_DEF,
  parameter int MAX_PAYLOAD = saff_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  // request side
  input  wire logic       push,
  output logic            full,
  input  wire logic       crc_good_i,
  input  wire logic [7:0] frame_length_i,
  input  wire logic [7:0] source_address_i,
  input  wire logic [7:0] dest_address_i,
  input  wire logic [7:0] frame_type_i,
  // result side
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      action_o,
  output logic [7:0]      reply_dest_o,
  output logic [7:0]      reply_source_o,
  output logic [1:0]      reply_type_o,
  output logic [1:0]      reply_length_o,
  output logic            new_node_o,
  output logic [7:0]      deliver_source_o,
  output logic [7:0]      deliver_length_o,
  output logic [3:0]      attached_count_o
);

  import saff_pkg::*;

  logic [7:0] coord_q;
  logic       mid_push, mid_empty, mid_pop;
  req_t       front_req, mid_req;
  logic       out_push, out_full;
  res_t       back_res, out_res;

  // Coordinator address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (cfg_we_i) begin
      coord_q <= cfg_data_i;
    end
  end

  saff_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .push_i          (push),
    .q_full_i        (full),
    .crc_good_i      (crc_good_i),
    .frame_length_i  (frame_length_i),
    .source_address_i(source_address_i),
    .dest_address_i  (dest_address_i),
    .frame_type_i    (frame_type_i),
    .coord_address_i (coord_q),
    .q_push_o        (mid_push),
    .req_o           (front_req)
  );

  saff_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(front_req),
    .full_o (full),
    .pop_i  (mid_pop),
    .rdata_o(mid_req),
    .empty_o(mid_empty)
  );

  saff_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coord_address_i(coord_q),
    .q_empty_i      (mid_empty),
    .q_req_i        (mid_req),
    .q_pop_o        (mid_pop),
    .out_full_i     (out_full),
    .out_push_o     (out_push),
    .out_res_o      (back_res)
  );

  saff_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(back_res),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_res),
    .empty_o(empty)
  );

  // Result fields
  assign action_o         = out_res.action;
  assign reply_dest_o     = out_res.reply_dest;
  assign reply_source_o   = out_res.reply_source;
  assign reply_type_o     = out_res.reply_type;
  assign reply_length_o   = out_res.reply_length;
  assign new_node_o       = out_res.new_node;
  assign deliver_source_o = out_res.deliver_source;
  assign deliver_length_o = out_res.deliver_length;
  assign attached_count_o = out_res.attached_count;

endmodule

`default_nettype wire

@@ sv/saff_sva.sv @@
// Port-level checker for the sink frame filter, bound to the top level.
`default_nettype none

`include "sink_attach_frame_filter_macros.svh"

module saff_sva #(
  parameter int MAX_NODES = saff_pkg::MAX_NODES_DEF
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] action_o,
  input wire logic [1:0] reply_type_o,
  input wire logic [1:0] reply_length_o,
  input wire logic       new_node_o,
  input wire logic [7:0] deliver_source_o,
  input wire logic [7:0] deliver_length_o,
  input wire logic [3:0] attached_count_o
);

  import saff_pkg::*;

  // A node is only added by a successful attach reply
  `SAFF_ASSERT_NOW(a_new_node_reply, !empty && new_node_o, action_o == ACT_REPLY, "new node without reply")

  // Reply header is fixed whenever a reply goes out
  `SAFF_ASSERT_NOW(a_reply_hdr, !empty && (action_o == ACT_REPLY), (reply_type_o == TYPE_ATTACH_REPLY) && (reply_length_o == REPLY_LEN), "bad reply header")

  // Delivery fields stay zero unless a data frame is delivered
  `SAFF_ASSERT_NOW(a_deliver_zero, !empty && (action_o != ACT_DELIVER), (deliver_source_o == 8'd0) && (deliver_length_o == 8'd0), "stray delivery fields")

  // Node count never shrinks from one result to the next, and stays in range
  `SAFF_ASSERT_NEXT(a_count_mono, !empty && pop && (MAX_NODES < 16), empty || ((attached_count_o >= $past(attached_count_o)) && (attached_count_o <= 4'(MAX_NODES))), "node count went backwards or over limit")

endmodule

bind sink_attach_frame_filter saff_sva #(
  .MAX_NODES(MAX_NODES)
) u_saff_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .action_o        (action_o),
  .reply_type_o    (reply_type_o),
  .reply_length_o  (reply_length_o),
  .new_node_o      (new_node_o),
  .deliver_source_o(deliver_source_o),
  .deliver_length_o(deliver_length_o),
  .attached_count_o(attached_count_o)
);

`default_nettype wire

@@ tb/sv/tb_sink_attach_frame_filter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the sink frame filter: directed and random frame headers.

module tb_sink_attach_frame_filter;
  import saff_pkg::*;

  localparam int LEN_LIMIT   = MAX_PAYLOAD_DEF + 3;  // longest accepted length byte
  localparam int PHASE_ITEMS = 80;
  localparam int NUM_PHASES  = 5;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_IDLE    = 16;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic       crc_good;
    logic [7:0] frame_length;
    logic [7:0] source_address;
    logic [7:0] dest_address;
    logic [7:0] frame_type;
  } frame_hdr_t;

  // Verdict tracker: own copy of the node table and coordinator address
  class frame_verdict_tracker;
    logic [7:0] coord_addr = 8'h00;
    logic [7:0] node_list [MAX_NODES_DEF];
    int         node_total = 0;
    res_t       waiting_verdicts [$];
    int         mismatches = 0;

    // Verdict for one header; updates the node table on a new attach
    function res_t judge(frame_hdr_t h);
      res_t r;
      logic known;
      int   i;
      r = '0;
      known = 1'b0;
      if (!h.crc_good) begin
        r.action = ACT_BAD_CRC;
      end else if (h.frame_length > LEN_LIMIT) begin
        r.action = ACT_BAD_LENGTH;
      end else if (h.dest_address != coord_addr && h.dest_address != BCAST_ADDR) begin
        r.action = ACT_NOT_ADDRESSED;
      end else if (h.frame_type == TYPE_ATTACH_REQ) begin
        if (h.frame_length != HDR_LEN) begin
          r.action = ACT_BAD_TYPE;
        end else begin
          for (i = 0; i < node_total; i++)
            if (node_list[i] == h.source_address) known = 1'b1;
          if (!known && node_total >= MAX_NODES_DEF) begin
            r.action = ACT_TABLE_FULL;
          end else begin
            if (!known) begin
              node_list[node_total] = h.source_address;
              node_total++;
              r.new_node = 1'b1;
            end
            r.action       = ACT_REPLY;
            r.reply_dest   = h.source_address;
            r.reply_source = coord_addr;
            r.reply_type   = TYPE_ATTACH_REPLY;
            r.reply_length = REPLY_LEN;
          end
        end
      end else if (h.frame_type == TYPE_DATA) begin
        if (h.frame_length < HDR_LEN) begin
          r.action = ACT_BAD_TYPE;
        end else begin
          r.action         = ACT_DELIVER;
          r.deliver_source = h.source_address;
          r.deliver_length = h.frame_length - HDR_LEN;
        end
      end else begin
        r.action = ACT_BAD_TYPE;
      end
      r.attached_count = 4'(node_total);
      return r;
    endfunction

    // Accepted request: predict and queue its verdict
    function void note_request(frame_hdr_t h);
      waiting_verdicts.push_back(judge(h));
    endfunction

    function string show(res_t r);
      return $sformatf("act=%0d rdst=%h rsrc=%h rtyp=%0d rlen=%0d new=%b dsrc=%h dlen=%0d cnt=%0d",
                       r.action, r.reply_dest, r.reply_source, r.reply_type, r.reply_length,
                       r.new_node, r.deliver_source, r.deliver_length, r.attached_count);
    endfunction

    // Accepted result: compare against the oldest waiting verdict
    function void check_verdict(res_t got);
      res_t  want;
      string bad;
      if (waiting_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR %0t: result with no request waiting: %s", $realtime, show(got));
        return;
      end
      want = waiting_verdicts.pop_front();
      bad = "";
      if (got.action         !== want.action)         bad = {bad, " action"};
      if (got.reply_dest     !== want.reply_dest)     bad = {bad, " reply_dest"};
      if (got.reply_source   !== want.reply_source)   bad = {bad, " reply_source"};
      if (got.reply_type     !== want.reply_type)     bad = {bad, " reply_type"};
      if (got.reply_length   !== want.reply_length)   bad = {bad, " reply_length"};
      if (got.new_node       !== want.new_node)       bad = {bad, " new_node"};
      if (got.deliver_source !== want.deliver_source) bad = {bad, " deliver_source"};
      if (got.deliver_length !== want.deliver_length) bad = {bad, " deliver_length"};
      if (got.attached_count !== want.attached_count) bad = {bad, " attached_count"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR %0t: mismatch in%s\n  expected %s\n  actual   %s",
                   $realtime, bad, show(want), show(got));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       push;
  logic       full;
  frame_hdr_t hdr;
  logic       empty;
  logic       pop;
  logic [2:0] action;
  logic [7:0] reply_dest;
  logic [7:0] reply_source;
  logic [1:0] reply_type;
  logic [1:0] reply_length;
  logic       new_node;
  logic [7:0] deliver_source;
  logic [7:0] deliver_length;
  logic [3:0] attached_count;

  frame_verdict_tracker verdicts;
  logic [7:0]           coord_now;
  int                   tx_sent;
  int                   rx_taken;
  logic                 tx_fast;
  logic                 rx_fast;

  sink_attach_frame_filter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .crc_good_i       (hdr.crc_good),
    .frame_length_i   (hdr.frame_length),
    .source_address_i (hdr.source_address),
    .dest_address_i   (hdr.dest_address),
    .frame_type_i     (hdr.frame_type),
    .empty            (empty),
    .pop              (pop),
    .action_o         (action),
    .reply_dest_o     (reply_dest),
    .reply_source_o   (reply_source),
    .reply_type_o     (reply_type),
    .reply_length_o   (reply_length),
    .new_node_o       (new_node),
    .deliver_source_o (deliver_source),
    .deliver_length_o (deliver_length),
    .attached_count_o (attached_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random frame header: mostly well-formed attach and data, some broken, some noise
  function automatic frame_hdr_t draw_header(logic [7:0] coord);
    frame_hdr_t h;
    int         pick;
    h.crc_good       = 1'b1;
    h.source_address = 8'($urandom);
    h.dest_address   = ($urandom_range(0, 1) == 0) ? coord : BCAST_ADDR;
    h.frame_type     = TYPE_DATA;
    h.frame_length   = 8'($urandom_range(HDR_LEN, LEN_LIMIT));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // attach from a small pool so nodes repeat and the table fills
      h.frame_type   = TYPE_ATTACH_REQ;
      h.frame_length = HDR_LEN;
      if ($urandom_range(0, 9) != 0) h.source_address = 8'(17 * $urandom_range(0, 15));
    end else if (pick < 65) begin
      // well-formed data frame, defaults above
    end else if (pick < 88) begin
      // one defect in an otherwise good frame
      case ($urandom_range(0, 5))
        0: h.crc_good = 1'b0;
        1: h.frame_length = 8'($urandom_range(LEN_LIMIT + 1, 255));
        2: begin
          do h.dest_address = 8'($urandom);
          while (h.dest_address == coord || h.dest_address == BCAST_ADDR);
        end
        3: h.frame_type = 8'($urandom);
        4: begin
          h.frame_type   = TYPE_ATTACH_REQ;
          h.frame_length = 8'($urandom_range(0, LEN_LIMIT));
        end
        default: h.frame_length = 8'($urandom_range(0, HDR_LEN - 1));
      endcase
    end else begin
      h = frame_hdr_t'({$urandom, $urandom});
    end
    return h;
  endfunction

  // Offer one header and hold it until accepted
  task automatic send_header(frame_hdr_t h);
    int gap;
    if (tx_sent % 32 == 0) tx_fast = ($urandom_range(0, 2) == 0);
    gap = $urandom_range(0, MAX_IDLE);
    if (tx_fast) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    hdr  <= h;
    do @(posedge clk); while (full);
    verdicts.note_request(h);
    tx_sent++;
  endtask

  // Stop offering and wait until every verdict has come back
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (verdicts.waiting_verdicts.size() != 0);
  endtask

  task automatic write_coord(logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    verdicts.coord_addr = value;
    coord_now = value;
    cfg_we <= 1'b0;
  endtask

  // Directed headers; coordinator address is 0x5A here
  task automatic run_directed();
    send_header('{1'b0, 8'd255, 8'hFF, 8'h00, TYPE_ATTACH_REQ});
    send_header('{1'b0, 8'd3, 8'h00, coord_now, TYPE_ATTACH_REQ});
    send_header('{1'b1, 8'd255, 8'h00, coord_now, TYPE_DATA});
    send_header('{1'b1, 8'(LEN_LIMIT + 1), 8'h12, coord_now, TYPE_DATA});
    send_header('{1'b1, 8'(LEN_LIMIT), 8'h12, coord_now, TYPE_DATA});
    send_header('{1'b1, 8'd10, 8'h34, 8'h00, TYPE_DATA});
    send_header('{1'b1, 8'd10, 8'h34, coord_now + 8'd1, TYPE_DATA});
    send_header('{1'b1, 8'd3, 8'h77, BCAST_ADDR, TYPE_DATA});
    // short data frames
    send_header('{1'b1, 8'd2, 8'h77, coord_now, TYPE_DATA});
    send_header('{1'b1, 8'd0, 8'h77, coord_now, TYPE_DATA});
    // attach of wrong length
    send_header('{1'b1, 8'd4, 8'h11, coord_now, TYPE_ATTACH_REQ});
    send_header('{1'b1, 8'd0, 8'h11, BCAST_ADDR, TYPE_ATTACH_REQ});
    // new node, then the same node again
    send_header('{1'b1, 8'd3, 8'h00, coord_now, TYPE_ATTACH_REQ});
    send_header('{1'b1, 8'd3, 8'h00, BCAST_ADDR, TYPE_ATTACH_REQ});
    send_header('{1'b1, 8'd3, 8'hFF, BCAST_ADDR, TYPE_ATTACH_REQ});
    send_header('{1'b1, 8'd3, 8'hAA, coord_now, TYPE_ATTACH_REQ});
    // unknown types
    send_header('{1'b1, 8'd5, 8'h10, coord_now, 8'h00});
    send_header('{1'b1, 8'd5, 8'h10, coord_now, 8'(TYPE_ATTACH_REPLY)});
    send_header('{1'b1, 8'd5, 8'h10, coord_now, 8'hFF});
    send_header('{1'b1, 8'd5, 8'h10, BCAST_ADDR, 8'h80});
  endtask

  // Result side: random stalls, accept and check
  initial begin
    res_t got;
    int   stall;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_taken % 32 == 0) rx_fast = ($urandom_range(0, 2) == 0);
      stall = $urandom_range(0, MAX_IDLE);
      if (rx_fast) stall = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.action         = action_e'(action);
      got.reply_dest     = reply_dest;
      got.reply_source   = reply_source;
      got.reply_type     = reply_type;
      got.reply_length   = reply_length;
      got.new_node       = new_node;
      got.deliver_source = deliver_source;
      got.deliver_length = deliver_length;
      got.attached_count = attached_count;
      verdicts.check_verdict(got);
      rx_taken++;
    end
  end

  // Main sequence
  initial begin
    int p;
    int n;
    verdicts  = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = 8'h00;
    push      = 1'b0;
    hdr       = '0;
    coord_now = 8'h00;
    tx_sent   = 0;
    rx_taken  = 0;
    tx_fast   = 1'b0;
    rx_fast   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_coord(8'h5A);
    run_directed();
    settle();

    // random phases; address extremes included
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       write_coord(8'h00);
        1:       write_coord(8'hFF);
        3:       write_coord(8'h01);
        default: write_coord(8'($urandom));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_header(draw_header(coord_now));
      settle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    verdicts.mismatches += verdicts.waiting_verdicts.size();
    if (verdicts.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/saff_pkg.sv
sv/saff_fifo.sv
sv/saff_front.sv
sv/saff_back.sv
sv/sink_attach_frame_filter.sv
sv/saff_sva.sv
tb/sv/tb_sink_attach_frame_filter.sv
